// File: design/kv_cache_scatter_address_gen_assert.svh
// assertion macros used by kvsa_back
`ifndef KV_CACHE_SCATTER_ADDRESS_GEN_ASSERT_SVH
`define KV_CACHE_SCATTER_ADDRESS_GEN_ASSERT_SVH
`ifndef SYNTHESIS
`define KVSA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define KVSA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define KVSA_ASSERT_IMP(label, ante, cons, msg)
`define KVSA_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

// File: design/kvsa_pkg.sv
`default_nettype none
package kvsa_pkg;

  localparam int ADDR_W      = 44;
  localparam int IDX_W       = 32;
  localparam int ERR_W       = 2;
  localparam int SEQ_REG_W   = 13;
  localparam int INNER_REG_W = 17;
  localparam int HEAD_REG_W  = 9;
  localparam int BATCH_REG_W = 9;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 17;
  localparam int QUEUE_DEPTH = 4;

  localparam int MAX_SEQ_DEF   = 4096;
  localparam int MAX_INNER_DEF = 65536;
  localparam int MAX_HEADS_DEF = 256;
  localparam int MAX_BATCH_DEF = 256;
  localparam int DATA_BITS_DEF = 32;

  localparam logic [ERR_W-1:0] ERR_OK        = 2'd0;
  localparam logic [ERR_W-1:0] ERR_NEG_INDEX = 2'd1;
  localparam logic [ERR_W-1:0] ERR_OVERFLOW  = 2'd2;
  localparam logic [ERR_W-1:0] ERR_TOO_LONG  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_CIRCULAR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SEQ    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UPDATE_SEQ = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INNER      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HEADS      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BATCH      = 3'd5;

  typedef struct packed {
    logic start;
    logic end_inner;
    logic last;
  } kvsa_flags_t;

  function automatic int kvsa_bits(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  // zero acts as one, values above the bound act as the bound
  function automatic logic [31:0] kvsa_eff(input logic [31:0] v, input logic [31:0] bound);
    logic [31:0] r;
    r = v;
    if (v == 32'd0) begin
      r = 32'd1;
    end else if (v > bound) begin
      r = bound;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: design/kv_cache_scatter_address_gen.sv
// channel  | handshake                 | payload
// ---------+---------------------------+---------------------------------------------
// in       | in_valid / in_ready       | write_index, update_value
// out      | out_valid / out_ready     | cache_address, write_data, write_enable,
//          |                           | error_code, last_element
// cfg      | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// one element per cycle in a slice while out_ready allows; pop -> stage A -> outputs
// the first element of each slice holds the back end for the slice base multiplies,
// plus in circular mode with no slice error for the bit-serial start-position remainder
// a 4-entry queue lets the front keep taking beats while the back end computes or stalls
// reset is synchronous; cfg_ready is always high and registers reset to linear mode and ones
`default_nettype none
module kv_cache_scatter_address_gen import kvsa_pkg::*; #(
  parameter int MAX_SEQ   = MAX_SEQ_DEF,
  parameter int MAX_INNER = MAX_INNER_DEF,
  parameter int MAX_HEADS = MAX_HEADS_DEF,
  parameter int MAX_BATCH = MAX_BATCH_DEF,
  parameter int DATA_BITS = DATA_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [IDX_W-1:0] write_index,
  input  logic [DATA_BITS-1:0]    update_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [ADDR_W-1:0]       cache_address,
  output logic [DATA_BITS-1:0]    write_data,
  output logic                    write_enable,
  output logic [ERR_W-1:0]        error_code,
  output logic                    last_element,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  localparam int INNER_W = kvsa_bits(MAX_INNER);
  localparam int HEAD_W  = kvsa_bits(MAX_HEADS);
  localparam int BATCH_W = kvsa_bits(MAX_BATCH);
  localparam int Q_W     = $bits(kvsa_flags_t) + INNER_W + BATCH_W + HEAD_W + IDX_W + DATA_BITS;

  logic                   circular_mode;
  logic [SEQ_REG_W-1:0]   cache_len;
  logic [SEQ_REG_W-1:0]   update_seq_len;
  logic [INNER_REG_W-1:0] inner_count;
  logic [HEAD_REG_W-1:0]  heads_per_batch;
  logic [BATCH_REG_W-1:0] batch_count;

  logic [SEQ_REG_W-1:0]   ms_eff;
  logic [SEQ_REG_W-1:0]   us_eff;
  logic [INNER_REG_W-1:0] ic_eff;
  logic [HEAD_REG_W-1:0]  hp_eff;
  logic [BATCH_REG_W-1:0] bc_eff;

  kvsa_flags_t          f_flags;
  logic [INNER_W-1:0]   f_inner;
  logic [BATCH_W-1:0]   f_batch;
  logic [HEAD_W-1:0]    f_head;
  logic [IDX_W-1:0]     f_index;
  logic [DATA_BITS-1:0] f_data;
  logic                 q_push;
  logic                 q_push_ready;
  logic [Q_W-1:0]       q_in;
  logic                 q_pop_valid;
  logic                 q_pop;
  logic [Q_W-1:0]       q_out;

  kvsa_flags_t          b_flags;
  logic [INNER_W-1:0]   b_inner;
  logic [BATCH_W-1:0]   b_batch;
  logic [HEAD_W-1:0]    b_head;
  logic [IDX_W-1:0]     b_index;
  logic [DATA_BITS-1:0] b_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      circular_mode   <= 1'b0;
      cache_len       <= SEQ_REG_W'(1);
      update_seq_len  <= SEQ_REG_W'(1);
      inner_count     <= INNER_REG_W'(1);
      heads_per_batch <= HEAD_REG_W'(1);
      batch_count     <= BATCH_REG_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CIRCULAR:   circular_mode   <= cfg_data[0];
        REG_MAX_SEQ:    cache_len       <= cfg_data[SEQ_REG_W-1:0];
        REG_UPDATE_SEQ: update_seq_len  <= cfg_data[SEQ_REG_W-1:0];
        REG_INNER:      inner_count     <= cfg_data[INNER_REG_W-1:0];
        REG_HEADS:      heads_per_batch <= cfg_data[HEAD_REG_W-1:0];
        REG_BATCH:      batch_count     <= cfg_data[BATCH_REG_W-1:0];
        default: ;
      endcase
    end
  end

  assign ms_eff = SEQ_REG_W'(kvsa_eff(32'(cache_len), 32'(MAX_SEQ)));
  assign us_eff = SEQ_REG_W'(kvsa_eff(32'(update_seq_len), 32'(MAX_SEQ)));
  assign ic_eff = INNER_REG_W'(kvsa_eff(32'(inner_count), 32'(MAX_INNER)));
  assign hp_eff = HEAD_REG_W'(kvsa_eff(32'(heads_per_batch), 32'(MAX_HEADS)));
  assign bc_eff = BATCH_REG_W'(kvsa_eff(32'(batch_count), 32'(MAX_BATCH)));

  kvsa_front #(
    .MAX_SEQ   (MAX_SEQ),
    .MAX_INNER (MAX_INNER),
    .MAX_HEADS (MAX_HEADS),
    .MAX_BATCH (MAX_BATCH),
    .DATA_BITS (DATA_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .us_eff       (us_eff),
    .ic_eff       (ic_eff),
    .hp_eff       (hp_eff),
    .bc_eff       (bc_eff),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .write_index  (write_index),
    .update_value (update_value),
    .push         (q_push),
    .push_ready   (q_push_ready),
    .rec_flags    (f_flags),
    .rec_inner    (f_inner),
    .rec_batch    (f_batch),
    .rec_head     (f_head),
    .rec_index    (f_index),
    .rec_data     (f_data)
  );

  assign q_in = {f_flags, f_inner, f_batch, f_head, f_index, f_data};

  kvsa_queue #(
    .WIDTH (Q_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_ready (q_push_ready),
    .push_data  (q_in),
    .pop_valid  (q_pop_valid),
    .pop        (q_pop),
    .pop_data   (q_out)
  );

  assign {b_flags, b_inner, b_batch, b_head, b_index, b_data} = q_out;

  kvsa_back #(
    .MAX_SEQ   (MAX_SEQ),
    .MAX_INNER (MAX_INNER),
    .MAX_HEADS (MAX_HEADS),
    .MAX_BATCH (MAX_BATCH),
    .DATA_BITS (DATA_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .circular      (circular_mode),
    .ms_eff        (ms_eff),
    .us_eff        (us_eff),
    .ic_eff        (ic_eff),
    .hp_eff        (hp_eff),
    .rec_valid     (q_pop_valid),
    .rec_ready     (q_pop),
    .rec_flags     (b_flags),
    .rec_inner     (b_inner),
    .rec_batch     (b_batch),
    .rec_head      (b_head),
    .rec_index     (b_index),
    .rec_data      (b_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .cache_address (cache_address),
    .write_data    (write_data),
    .write_enable  (write_enable),
    .error_code    (error_code),
    .last_element  (last_element)
  );

endmodule
`default_nettype wire

// File: design/kvsa_front.sv
`default_nettype none
module kvsa_front import kvsa_pkg::*; #(
  parameter int MAX_SEQ   = MAX_SEQ_DEF,
  parameter int MAX_INNER = MAX_INNER_DEF,
  parameter int MAX_HEADS = MAX_HEADS_DEF,
  parameter int MAX_BATCH = MAX_BATCH_DEF,
  parameter int DATA_BITS = DATA_BITS_DEF,
  localparam int SEQ_W    = kvsa_bits(MAX_SEQ),
  localparam int INNER_W  = kvsa_bits(MAX_INNER),
  localparam int HEAD_W   = kvsa_bits(MAX_HEADS),
  localparam int BATCH_W  = kvsa_bits(MAX_BATCH)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [SEQ_REG_W-1:0]   us_eff,
  input  logic [INNER_REG_W-1:0] ic_eff,
  input  logic [HEAD_REG_W-1:0]  hp_eff,
  input  logic [BATCH_REG_W-1:0] bc_eff,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [IDX_W-1:0]       write_index,
  input  logic [DATA_BITS-1:0]   update_value,
  output logic                   push,
  input  logic                   push_ready,
  output kvsa_flags_t            rec_flags,
  output logic [INNER_W-1:0]     rec_inner,
  output logic [BATCH_W-1:0]     rec_batch,
  output logic [HEAD_W-1:0]      rec_head,
  output logic [IDX_W-1:0]       rec_index,
  output logic [DATA_BITS-1:0]   rec_data
);

  logic [INNER_W-1:0] inner_cnt;
  logic [SEQ_W-1:0]   seq_cnt;
  logic [HEAD_W-1:0]  head_cnt;
  logic [BATCH_W-1:0] batch_cnt;
  logic end_inner, end_seq, end_head, end_batch;

  // a counter at or above its limit counts as being at its end
  assign end_inner = (32'(inner_cnt) + 32'd1) >= 32'(ic_eff);
  assign end_seq   = (32'(seq_cnt) + 32'd1) >= 32'(us_eff);
  assign end_head  = (32'(head_cnt) + 32'd1) >= 32'(hp_eff);
  assign end_batch = (32'(batch_cnt) + 32'd1) >= 32'(bc_eff);

  assign in_ready = push_ready;
  assign push     = in_valid && push_ready;

  assign rec_flags.start     = (inner_cnt == '0) && (seq_cnt == '0);
  assign rec_flags.end_inner = end_inner;
  assign rec_flags.last      = end_inner && end_seq && end_head && end_batch;
  assign rec_inner = inner_cnt;
  assign rec_batch = batch_cnt;
  assign rec_head  = head_cnt;
  assign rec_index = write_index;
  assign rec_data  = update_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      inner_cnt <= '0;
      seq_cnt   <= '0;
      head_cnt  <= '0;
      batch_cnt <= '0;
    end else if (push) begin
      if (!end_inner) begin
        inner_cnt <= inner_cnt + INNER_W'(1);
      end else begin
        inner_cnt <= '0;
        if (!end_seq) begin
          seq_cnt <= seq_cnt + SEQ_W'(1);
        end else begin
          seq_cnt <= '0;
          if (!end_head) begin
            head_cnt <= head_cnt + HEAD_W'(1);
          end else begin
            head_cnt  <= '0;
            batch_cnt <= end_batch ? '0 : batch_cnt + BATCH_W'(1);
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: design/kvsa_queue.sv
`default_nettype none
module kvsa_queue import kvsa_pkg::*; #(
  parameter int WIDTH   = 8,
  parameter int DEPTH   = QUEUE_DEPTH,
  localparam int PTR_W  = kvsa_bits(DEPTH),
  localparam int CNT_W  = kvsa_bits(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;

  assign push_ready = count != CNT_W'(DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + PTR_W'(1);
      end
      if (pop) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

// File: design/kvsa_back.sv
`default_nettype none
`include "kv_cache_scatter_address_gen_assert.svh"
module kvsa_back import kvsa_pkg::*; #(
  parameter int MAX_SEQ    = MAX_SEQ_DEF,
  parameter int MAX_INNER  = MAX_INNER_DEF,
  parameter int MAX_HEADS  = MAX_HEADS_DEF,
  parameter int MAX_BATCH  = MAX_BATCH_DEF,
  parameter int DATA_BITS  = DATA_BITS_DEF,
  localparam int POS_W     = kvsa_bits(MAX_SEQ),
  localparam int INNER_W   = kvsa_bits(MAX_INNER),
  localparam int HEAD_W    = kvsa_bits(MAX_HEADS),
  localparam int BATCH_W   = kvsa_bits(MAX_BATCH)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   circular,
  input  logic [SEQ_REG_W-1:0]   ms_eff,
  input  logic [SEQ_REG_W-1:0]   us_eff,
  input  logic [INNER_REG_W-1:0] ic_eff,
  input  logic [HEAD_REG_W-1:0]  hp_eff,
  input  logic                   rec_valid,
  output logic                   rec_ready,
  input  kvsa_flags_t            rec_flags,
  input  logic [INNER_W-1:0]     rec_inner,
  input  logic [BATCH_W-1:0]     rec_batch,
  input  logic [HEAD_W-1:0]      rec_head,
  input  logic [IDX_W-1:0]       rec_index,
  input  logic [DATA_BITS-1:0]   rec_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [ADDR_W-1:0]      cache_address,
  output logic [DATA_BITS-1:0]   write_data,
  output logic                   write_enable,
  output logic [ERR_W-1:0]       error_code,
  output logic                   last_element
);

  localparam int SLICE_W   = ((BATCH_W + HEAD_REG_W > HEAD_W) ? BATCH_W + HEAD_REG_W : HEAD_W) + 1;
  localparam int BASE1_W   = SLICE_W + SEQ_REG_W;
  localparam int BASE2_W   = BASE1_W + INNER_REG_W;
  localparam int ELEM_W    = POS_W + INNER_REG_W;
  localparam int DIV_CNT_W = kvsa_bits(IDX_W - 1);

  localparam int STATE_W = 3;
  localparam logic [STATE_W-1:0] ST_RUN   = 3'd0;
  localparam logic [STATE_W-1:0] ST_SLICE = 3'd1;
  localparam logic [STATE_W-1:0] ST_MS    = 3'd2;
  localparam logic [STATE_W-1:0] ST_IC    = 3'd3;
  localparam logic [STATE_W-1:0] ST_DIV   = 3'd4;

  logic [STATE_W-1:0]   state;
  logic                 prepared;
  logic [IDX_W-1:0]     raw_l;
  logic [BATCH_W-1:0]   batch_l;
  logic [HEAD_W-1:0]    head_l;
  logic [SLICE_W-1:0]   slice_idx;
  logic [BASE1_W-1:0]   base1;
  logic [ADDR_W-1:0]    slice_base;
  logic [ERR_W-1:0]     slice_error;
  logic [POS_W-1:0]     pos;
  logic [SEQ_REG_W:0]   rem;
  logic [IDX_W-2:0]     div_sh;
  logic [DIV_CNT_W-1:0] div_cnt;

  logic                 valid_a;
  logic [ADDR_W-1:0]    base_a;
  logic [ELEM_W-1:0]    prod_a;
  logic [INNER_W-1:0]   inner_a;
  logic [ERR_W-1:0]     err_a;
  logic [DATA_BITS-1:0] data_a;
  logic                 last_a;

  logic [SLICE_W-1:0]   slice_w;
  logic [BASE1_W-1:0]   base1_w;
  logic [BASE2_W-1:0]   base2_w;
  logic [ELEM_W-1:0]    elem_prod;
  logic [SEQ_REG_W:0]   trial;
  logic [SEQ_REG_W:0]   rem_next;
  logic [ERR_W-1:0]     err_w;
  logic [POS_W-1:0]     pos_next;
  logic                 calc_go;
  logic                 div_need;
  logic                 advance_a;
  logic                 pop;

  assign slice_w   = batch_l * hp_eff + head_l;
  assign base1_w   = slice_idx * ms_eff;
  assign base2_w   = base1 * ic_eff;
  assign elem_prod = pos * ic_eff;

  // restoring remainder, one index bit per cycle
  assign trial    = {rem[SEQ_REG_W-1:0], div_sh[IDX_W-2]};
  assign rem_next = (trial >= {1'b0, ms_eff}) ? trial - {1'b0, ms_eff} : trial;

  assign pos_next = ((32'(pos) + 32'd1) >= 32'(ms_eff)) ? '0 : pos + POS_W'(1);

  always_comb begin
    if (us_eff > ms_eff) begin
      err_w = ERR_TOO_LONG;
    end else if (rec_index[IDX_W-1]) begin
      err_w = ERR_NEG_INDEX;
    end else if (!circular &&
                 ((IDX_W + 1)'(rec_index) + (IDX_W + 1)'(us_eff)) > (IDX_W + 1)'(ms_eff)) begin
      err_w = ERR_OVERFLOW;
    end else begin
      err_w = ERR_OK;
    end
  end

  assign div_need  = circular && (slice_error == ERR_OK);
  assign calc_go   = (state == ST_RUN) && rec_valid && rec_flags.start && !prepared;
  assign advance_a = valid_a && (!out_valid || out_ready);
  assign pop       = (state == ST_RUN) && rec_valid && (!rec_flags.start || prepared) &&
                     (!valid_a || advance_a);
  assign rec_ready = pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_RUN;
      prepared  <= 1'b0;
      valid_a   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ST_RUN: begin
          if (calc_go) begin
            state <= ST_SLICE;
          end
        end
        ST_SLICE: state <= ST_MS;
        ST_MS:    state <= ST_IC;
        ST_IC: begin
          state <= div_need ? ST_DIV : ST_RUN;
        end
        ST_DIV: begin
          if (div_cnt == '0) begin
            state <= ST_RUN;
          end
        end
        default: state <= ST_RUN;
      endcase

      if ((state == ST_IC && !div_need) || (state == ST_DIV && div_cnt == '0)) begin
        prepared <= 1'b1;
      end else if (pop && rec_flags.start) begin
        prepared <= 1'b0;
      end

      if (pop) begin
        valid_a <= 1'b1;
      end else if (advance_a) begin
        valid_a <= 1'b0;
      end

      if (advance_a) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (calc_go) begin
      raw_l       <= rec_index;
      batch_l     <= rec_batch;
      head_l      <= rec_head;
      slice_error <= err_w;
      div_sh      <= rec_index[IDX_W-2:0];
      rem         <= '0;
      div_cnt     <= DIV_CNT_W'(IDX_W - 2);
    end
    if (state == ST_SLICE) begin
      slice_idx <= slice_w;
    end
    if (state == ST_MS) begin
      base1 <= base1_w;
    end
    if (state == ST_IC) begin
      slice_base <= ADDR_W'(base2_w);
      if (!div_need) begin
        pos <= (slice_error == ERR_OK) ? POS_W'(raw_l) : '0;
      end
    end
    if (state == ST_DIV) begin
      rem     <= rem_next;
      div_sh  <= div_sh << 1;
      div_cnt <= div_cnt - DIV_CNT_W'(1);
      if (div_cnt == '0) begin
        pos <= POS_W'(rem_next);
      end
    end
    if (pop) begin
      base_a  <= slice_base;
      prod_a  <= elem_prod;
      inner_a <= rec_inner;
      err_a   <= slice_error;
      data_a  <= rec_data;
      last_a  <= rec_flags.last;
      if (rec_flags.end_inner) begin
        pos <= pos_next;
      end
    end
    if (advance_a) begin
      if (err_a == ERR_OK) begin
        cache_address <= base_a + ADDR_W'(prod_a) + ADDR_W'(inner_a);
        write_data    <= data_a;
        write_enable  <= 1'b1;
      end else begin
        cache_address <= '0;
        write_data    <= '0;
        write_enable  <= 1'b0;
      end
      error_code   <= err_a;
      last_element <= last_a;
    end
  end

  `KVSA_ASSERT_IMP(a_no_pop_in_calc, state != ST_RUN, !rec_ready, "beat popped during slice setup")
  `KVSA_ASSERT_IMP(a_start_prepared, rec_ready && rec_flags.start, prepared, "slice start popped early")
  `KVSA_ASSERT_NXT(a_calc_entry, calc_go, state == ST_SLICE, "slice setup not entered")
  `KVSA_ASSERT_IMP(a_enable_code, out_valid, write_enable == (error_code == ERR_OK), "enable mismatch")
  `KVSA_ASSERT_IMP(a_suppressed_zero, out_valid && !write_enable, cache_address == '0 && write_data == '0, "suppressed beat not zero")

endmodule
`default_nettype wire

// File: verif/kv_cache_scatter_address_gen_tb.sv
`timescale 1ns / 100ps
module kv_cache_scatter_address_gen_tb;
  import kvsa_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_BEATS = 625;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [31:0]       data;
    logic              we;
    logic [ERR_W-1:0]  err;
    logic              last;
  } scatter_write_t;

  typedef enum logic {ROW_REG, ROW_BEAT} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    logic [31:0]           index;
    logic [31:0]           value;
    logic                  typed;
    scatter_write_t        want;
  } stim_row_t;

  localparam scatter_write_t NO_WANT = '0;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [IDX_W-1:0] write_index = '0;
  logic [31:0] update_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [ADDR_W-1:0] cache_address;
  logic [31:0] write_data;
  logic write_enable;
  logic [ERR_W-1:0] error_code;
  logic last_element;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  kv_cache_scatter_address_gen dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .write_index(write_index),
    .update_value(update_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cache_address(cache_address),
    .write_data(write_data),
    .write_enable(write_enable),
    .error_code(error_code),
    .last_element(last_element),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // predictor copy of registers and walk state
  logic                  circ_mode = 1'b0;
  logic [SEQ_REG_W-1:0]  max_len_reg = 13'd1;
  logic [SEQ_REG_W-1:0]  upd_len_reg = 13'd1;
  logic [INNER_REG_W-1:0] inner_reg = 17'd1;
  logic [HEAD_REG_W-1:0] heads_reg = 9'd1;
  logic [BATCH_REG_W-1:0] batches_reg = 9'd1;
  logic [15:0]           inner_pos = '0;
  logic [11:0]           seq_pos = '0;
  logic [7:0]            head_pos = '0;
  logic [7:0]            batch_pos = '0;
  logic [11:0]           cache_row = '0;
  logic [ADDR_W-1:0]     slice_base = '0;
  logic [ERR_W-1:0]      slice_err = ERR_OK;

  scatter_write_t pending_writes [$];
  int error_beats = 0;
  int cycle_count = 0;
  bit idle_on = 1'b1;
  bit beat_typed = 1'b0;
  scatter_write_t beat_want = '0;

  stim_row_t directed_rows [$] = '{
    '{ROW_BEAT, REG_CIRCULAR, 17'd0, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1,
      '{44'd0, 32'hFFFF_FFFF, 1'b1, ERR_OK, 1'b1}},
    '{ROW_BEAT, REG_CIRCULAR, 17'd0, 32'hFFFF_FFFF, 32'h1234_5678, 1'b1,
      '{44'd0, 32'd0, 1'b0, ERR_NEG_INDEX, 1'b1}},
    '{ROW_BEAT, REG_CIRCULAR, 17'd0, 32'h0000_0001, 32'h0000_0000, 1'b1,
      '{44'd0, 32'd0, 1'b0, ERR_OVERFLOW, 1'b1}},
    '{ROW_BEAT, REG_CIRCULAR, 17'd0, 32'h7FFF_FFFF, 32'hAAAA_AAAA, 1'b1,
      '{44'd0, 32'd0, 1'b0, ERR_OVERFLOW, 1'b1}},
    '{ROW_BEAT, REG_CIRCULAR, 17'd0, 32'h8000_0000, 32'h5555_5555, 1'b1,
      '{44'd0, 32'd0, 1'b0, ERR_NEG_INDEX, 1'b1}},
    '{ROW_REG, REG_SPARE_A, 17'h1FFFF, 32'd0, 32'd0, 1'b0, NO_WANT},
    '{ROW_REG, REG_SPARE_B, 17'h00000, 32'd0, 32'd0, 1'b0, NO_WANT},
    '{ROW_BEAT, REG_CIRCULAR, 17'd0, 32'h0000_0000, 32'h0000_0000, 1'b1,
      '{44'd0, 32'd0, 1'b1, ERR_OK, 1'b1}},
    '{ROW_REG, REG_UPDATE_SEQ, 17'd2, 32'd0, 32'd0, 1'b0, NO_WANT},
    '{ROW_BEAT, REG_CIRCULAR, 17'd0, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1,
      '{44'd0, 32'd0, 1'b0, ERR_TOO_LONG, 1'b0}},
    '{ROW_BEAT, REG_CIRCULAR, 17'd0, 32'h0000_0000, 32'h0000_0002, 1'b1,
      '{44'd0, 32'd0, 1'b0, ERR_TOO_LONG, 1'b1}},
    '{ROW_REG, REG_MAX_SEQ, 17'h01FFF, 32'd0, 32'd0, 1'b0, NO_WANT},
    '{ROW_REG, REG_UPDATE_SEQ, 17'd0, 32'd0, 32'd0, 1'b0, NO_WANT},
    '{ROW_REG, REG_CIRCULAR, 17'd1, 32'd0, 32'd0, 1'b0, NO_WANT},
    '{ROW_REG, REG_INNER, 17'h1FFFF, 32'd0, 32'd0, 1'b0, NO_WANT},
    '{ROW_REG, REG_HEADS, 17'h001FF, 32'd0, 32'd0, 1'b0, NO_WANT},
    '{ROW_REG, REG_BATCH, 17'h001FF, 32'd0, 32'd0, 1'b0, NO_WANT},
    '{ROW_BEAT, REG_CIRCULAR, 17'd0, 32'h7FFF_FFFF, 32'hDEAD_BEEF, 1'b1,
      '{44'h000_0FFF_0000, 32'hDEAD_BEEF, 1'b1, ERR_OK, 1'b0}},
    '{ROW_BEAT, REG_CIRCULAR, 17'd0, 32'h0000_0000, 32'h0F0F_0F0F, 1'b0, NO_WANT},
    // inner count shrinks to the running inner position
    '{ROW_REG, REG_INNER, 17'd2, 32'd0, 32'd0, 1'b0, NO_WANT},
    '{ROW_BEAT, REG_CIRCULAR, 17'd0, 32'h0000_0000, 32'h1357_9BDF, 1'b0, NO_WANT},
    '{ROW_BEAT, REG_CIRCULAR, 17'd0, 32'd5000, 32'h2468_ACE0, 1'b0, NO_WANT},
    '{ROW_BEAT, REG_CIRCULAR, 17'd0, 32'h0000_0000, 32'h1111_1111, 1'b0, NO_WANT},
    '{ROW_REG, REG_CIRCULAR, 17'd0, 32'd0, 32'd0, 1'b0, NO_WANT},
    '{ROW_REG, REG_MAX_SEQ, 17'd3, 32'd0, 32'd0, 1'b0, NO_WANT},
    '{ROW_REG, REG_UPDATE_SEQ, 17'd2, 32'd0, 32'd0, 1'b0, NO_WANT},
    '{ROW_BEAT, REG_CIRCULAR, 17'd0, 32'd1, 32'h0000_00A1, 1'b0, NO_WANT},
    '{ROW_BEAT, REG_CIRCULAR, 17'd0, 32'd0, 32'h0000_00A2, 1'b0, NO_WANT},
    '{ROW_BEAT, REG_CIRCULAR, 17'd0, 32'd0, 32'h0000_00A3, 1'b0, NO_WANT},
    '{ROW_BEAT, REG_CIRCULAR, 17'd0, 32'd0, 32'h0000_00A4, 1'b0, NO_WANT},
    '{ROW_BEAT, REG_CIRCULAR, 17'd0, 32'd2, 32'h0000_00B1, 1'b0, NO_WANT},
    '{ROW_BEAT, REG_CIRCULAR, 17'd0, 32'd0, 32'h0000_00B2, 1'b0, NO_WANT},
    '{ROW_BEAT, REG_CIRCULAR, 17'd0, 32'd0, 32'h0000_00B3, 1'b0, NO_WANT},
    '{ROW_BEAT, REG_CIRCULAR, 17'd0, 32'd0, 32'h0000_00B4, 1'b0, NO_WANT},
    '{ROW_REG, REG_CIRCULAR, 17'd1, 32'd0, 32'd0, 1'b0, NO_WANT},
    '{ROW_REG, REG_UPDATE_SEQ, 17'd3, 32'd0, 32'd0, 1'b0, NO_WANT},
    '{ROW_REG, REG_INNER, 17'd0, 32'd0, 32'd0, 1'b0, NO_WANT},
    '{ROW_BEAT, REG_CIRCULAR, 17'd0, 32'd2, 32'h0000_00C1, 1'b0, NO_WANT},
    '{ROW_BEAT, REG_CIRCULAR, 17'd0, 32'd0, 32'h0000_00C2, 1'b0, NO_WANT},
    '{ROW_BEAT, REG_CIRCULAR, 17'd0, 32'd0, 32'h0000_00C3, 1'b0, NO_WANT},
    '{ROW_REG, REG_MAX_SEQ, 17'd0, 32'd0, 32'd0, 1'b0, NO_WANT},
    '{ROW_REG, REG_UPDATE_SEQ, 17'd1, 32'd0, 32'd0, 1'b0, NO_WANT},
    '{ROW_REG, REG_HEADS, 17'd0, 32'd0, 32'd0, 1'b0, NO_WANT},
    '{ROW_REG, REG_BATCH, 17'd2, 32'd0, 32'd0, 1'b0, NO_WANT},
    '{ROW_BEAT, REG_CIRCULAR, 17'd0, 32'd9, 32'h0000_00D1, 1'b0, NO_WANT},
    '{ROW_BEAT, REG_CIRCULAR, 17'd0, 32'd0, 32'h0000_00D2, 1'b0, NO_WANT}
  };

  function automatic int unsigned clamp_reg(input int unsigned v, input int unsigned bound);
    if (v == 0) begin
      return 1;
    end
    return (v > bound) ? bound : v;
  endfunction

  function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_CIRCULAR:   circ_mode = data[0];
      REG_MAX_SEQ:    max_len_reg = data[SEQ_REG_W-1:0];
      REG_UPDATE_SEQ: upd_len_reg = data[SEQ_REG_W-1:0];
      REG_INNER:      inner_reg = data[INNER_REG_W-1:0];
      REG_HEADS:      heads_reg = data[HEAD_REG_W-1:0];
      REG_BATCH:      batches_reg = data[BATCH_REG_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic scatter_write_t predict_write(input logic [31:0] idx,
                                                   input logic [31:0] val);
    int unsigned ms, us, ic, hp, bc;
    logic [63:0] slice, addr;
    logic end_inner, end_seq, end_head, end_batch;
    scatter_write_t r;
    ms = clamp_reg(max_len_reg, MAX_SEQ_DEF);
    us = clamp_reg(upd_len_reg, MAX_SEQ_DEF);
    ic = clamp_reg(inner_reg, MAX_INNER_DEF);
    hp = clamp_reg(heads_reg, MAX_HEADS_DEF);
    bc = clamp_reg(batches_reg, MAX_BATCH_DEF);
    if (inner_pos == 0 && seq_pos == 0) begin
      slice = 64'(batch_pos) * 64'(hp) + 64'(head_pos);
      slice_base = ADDR_W'(slice * 64'(ms) * 64'(ic));
      cache_row = '0;
      if (us > ms) begin
        slice_err = ERR_TOO_LONG;
      end else if (idx[31]) begin
        slice_err = ERR_NEG_INDEX;
      end else if (!circ_mode && 64'(idx) + 64'(us) > 64'(ms)) begin
        slice_err = ERR_OVERFLOW;
      end else begin
        slice_err = ERR_OK;
        cache_row = circ_mode ? 12'(idx % ms) : 12'(idx);
      end
    end
    addr = 64'(slice_base) + 64'(cache_row) * 64'(ic) + 64'(inner_pos);
    end_inner = (32'(inner_pos) + 32'd1) >= ic;
    end_seq = (32'(seq_pos) + 32'd1) >= us;
    end_head = (32'(head_pos) + 32'd1) >= hp;
    end_batch = (32'(batch_pos) + 32'd1) >= bc;
    r = '0;
    if (slice_err == ERR_OK) begin
      r.addr = addr[ADDR_W-1:0];
      r.data = val;
      r.we = 1'b1;
    end
    r.err = slice_err;
    r.last = end_inner && end_seq && end_head && end_batch;
    if (!end_inner) begin
      inner_pos = inner_pos + 16'd1;
    end else begin
      inner_pos = '0;
      cache_row = ((32'(cache_row) + 32'd1) >= ms) ? 12'd0 : cache_row + 12'd1;
      if (!end_seq) begin
        seq_pos = seq_pos + 12'd1;
      end else begin
        seq_pos = '0;
        if (!end_head) begin
          head_pos = head_pos + 8'd1;
        end else begin
          head_pos = '0;
          batch_pos = end_batch ? 8'd0 : batch_pos + 8'd1;
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin : check_beats
    scatter_write_t due;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_writes.size() == 0) begin
          $display("%0t: write beat with none expected, expected none actual %h",
                   $time, cache_address);
          error_beats++;
        end else begin
          due = pending_writes.pop_front();
          if (cache_address !== due.addr) begin
            $display("%0t: cache_address expected %h actual %h", $time, due.addr,
                     cache_address);
            error_beats++;
          end
          if (write_data !== due.data) begin
            $display("%0t: write_data expected %h actual %h", $time, due.data, write_data);
            error_beats++;
          end
          if (write_enable !== due.we) begin
            $display("%0t: write_enable expected %b actual %b", $time, due.we,
                     write_enable);
            error_beats++;
          end
          if (error_code !== due.err) begin
            $display("%0t: error_code expected %0d actual %0d", $time, due.err, error_code);
            error_beats++;
          end
          if (last_element !== due.last) begin
            $display("%0t: last_element expected %b actual %b", $time, due.last,
                     last_element);
            error_beats++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        apply_register(cfg_index, cfg_data);
      end
      if (in_valid && in_ready) begin
        due = predict_write(write_index, update_value);
        pending_writes.push_back(beat_typed ? beat_want : due);
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= !idle_on || ($urandom_range(99) >= 36);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // called at a falling edge, returns at the accepting rising edge
  task automatic send_beat(input logic [31:0] idx, input logic [31:0] val,
                           input bit typed, input scatter_write_t want);
    while (idle_on && $urandom_range(99) < 36) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    beat_typed = typed;
    beat_want = want;
    in_valid <= 1'b1;
    write_index <= idx;
    update_value <= val;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_writes();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_writes.size() != 0) begin
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int sent;
    int beats;
    int unsigned ms, us, pick;
    int unsigned ms_val, us_val, ic_val, hp_val, bc_val;
    logic [31:0] idx;
    sent = 0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_REG) begin
        drain_writes();
        write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
      end else begin
        @(negedge clk);
        send_beat(directed_rows[i].index, directed_rows[i].value, directed_rows[i].typed,
                  directed_rows[i].want);
      end
    end

    for (int phase = 0; sent < RANDOM_BEATS; phase++) begin
      drain_writes();
      idle_on = (phase != 3);
      if ($urandom_range(7) == 0) begin
        case ($urandom_range(2))
          0: ms_val = 0;
          1: ms_val = MAX_SEQ_DEF;
          default: ms_val = 13'h1FFF;
        endcase
      end else begin
        ms_val = $urandom_range(1, 12);
      end
      ms = clamp_reg(ms_val, MAX_SEQ_DEF);
      if ($urandom_range(9) == 0) begin
        us_val = ms + $urandom_range(1, 2);
      end else begin
        us_val = $urandom_range(1, (ms < 6) ? ms : 6);
      end
      if ($urandom_range(7) == 0) begin
        case ($urandom_range(2))
          0: ic_val = 0;
          1: ic_val = MAX_INNER_DEF;
          default: ic_val = 17'h1FFFF;
        endcase
      end else begin
        ic_val = $urandom_range(1, 4);
      end
      hp_val = ($urandom_range(7) == 0) ? MAX_HEADS_DEF : $urandom_range(1, 3);
      bc_val = ($urandom_range(7) == 0) ? 9'h1FF : $urandom_range(1, 3);
      write_reg(REG_CIRCULAR, 17'($urandom_range(1)));
      write_reg(REG_MAX_SEQ, 17'(ms_val));
      write_reg(REG_UPDATE_SEQ, 17'(us_val));
      write_reg(REG_INNER, 17'(ic_val));
      write_reg(REG_HEADS, 17'(hp_val));
      write_reg(REG_BATCH, 17'(bc_val));

      beats = $urandom_range(20, 60);
      for (int k = 0; k < beats && sent < RANDOM_BEATS; k++) begin
        if (phase == 1 && k == beats / 2) begin
          drain_writes();
        end
        @(negedge clk);
        if (inner_pos == 0 && seq_pos == 0) begin
          ms = clamp_reg(max_len_reg, MAX_SEQ_DEF);
          us = clamp_reg(upd_len_reg, MAX_SEQ_DEF);
          pick = $urandom_range(99);
          if (pick < 70) begin
            if (circ_mode) begin
              idx = $urandom_range(1) ? $urandom_range(0, 3 * ms) : ($urandom & 32'h7FFF_FFFF);
            end else begin
              idx = (us <= ms) ? $urandom_range(0, ms - us) : $urandom_range(0, ms);
            end
          end else if (pick < 80) begin
            idx = ms - us + $urandom_range(1, 3);
          end else if (pick < 90) begin
            idx = $urandom | 32'h8000_0000;
          end else begin
            idx = $urandom;
          end
        end else begin
          idx = $urandom;
        end
        send_beat(idx, $urandom, 1'b0, NO_WANT);
        sent++;
      end
    end

    drain_writes();
    repeat (40) @(negedge clk);
    if (error_beats == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
